@@ rtl/ofr_pkg.sv @@
// Package: widths, formats, sequencer states and helper types for the reprojection core.
`default_nettype none
package ofr_pkg;
    localparam int PosWidth  = 32;
    localparam int QuatWidth = 32;
    localparam int FracBits  = 30;
    localparam int EntWidth  = FracBits + 2;
    localparam int VecWidth  = PosWidth + 2;
    localparam int DiffWidth = PosWidth + 1;
    // Serial multiplier operand widths: multiplicand signed, multiplier signed.
    localparam int MulAWidth = 36;
    localparam int MulBWidth = 34;
    localparam int ProdWidth = MulAWidth + MulBWidth;
    localparam int MulCntW   = $clog2(MulBWidth + 1);

    localparam logic OpAttitude = 1'b0;
    localparam logic OpOdometry = 1'b1;

    typedef logic signed [PosWidth-1:0]  t_pos;
    typedef logic signed [QuatWidth-1:0] t_quat;
    typedef logic signed [EntWidth-1:0]  t_ent;
    typedef logic signed [VecWidth-1:0]  t_vec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_MAT1,
        ST_ROT1,
        ST_PROD2,
        ST_MAT2,
        ST_ROT2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctl;

    function automatic t_ent sat_ent(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd1 <<< (EntWidth - 1);
        hi = hi - 40'sd1;
        lo = -hi - 40'sd1;
        if (v > hi) return hi[EntWidth-1:0];
        if (v < lo) return lo[EntWidth-1:0];
        return v[EntWidth-1:0];
    endfunction

    function automatic t_vec sat_vec(input logic signed [VecWidth+3:0] v);
        logic signed [VecWidth+3:0] hi;
        logic signed [VecWidth+3:0] lo;
        hi = {{4{1'b0}}, 1'b0, {(VecWidth-1){1'b1}}};
        lo = -hi - 1;
        if (v > hi) return hi[VecWidth-1:0];
        if (v < lo) return lo[VecWidth-1:0];
        return v[VecWidth-1:0];
    endfunction

    function automatic t_pos sat_pos(input logic signed [VecWidth:0] v);
        logic signed [VecWidth:0] hi;
        logic signed [VecWidth:0] lo;
        hi = {{(VecWidth-PosWidth+2){1'b0}}, {(PosWidth-1){1'b1}}};
        lo = -hi - 1;
        if (v > hi) return hi[PosWidth-1:0];
        if (v < lo) return lo[PosWidth-1:0];
        return v[PosWidth-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/ofr_if.sv @@
// Interfaces: request and result channels of the reprojection core.
`default_nettype none
interface ofr_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] quat_w;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    modport source (output valid, opcode, pos_x, pos_y, pos_z,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, opcode, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface ofr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [31:0] acc_z;
    logic [31:0] att_w;
    logic [31:0] att_x;
    logic [31:0] att_y;
    logic [31:0] att_z;
    modport source (output valid, acc_x, acc_y, acc_z, att_w, att_x, att_y, att_z,
                    input ready);
    modport sink (input valid, acc_x, acc_y, acc_z, att_w, att_x, att_y, att_z,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ofr_serial_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`default_nettype none
module ofr_serial_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [ofr_pkg::MulAWidth-1:0] i_a,
    input  wire logic signed [ofr_pkg::MulBWidth-1:0] i_b,
    output logic signed [ofr_pkg::ProdWidth-1:0]      o_prod,
    output ofr_pkg::t_mul_ctl                         o_ctl
);
    import ofr_pkg::*;

    logic signed [ProdWidth-1:0] r_acc;
    logic signed [ProdWidth-1:0] r_mcand;
    logic [MulBWidth-1:0]        r_mplier;
    logic [MulCntW-1:0]          r_cnt;
    logic                        r_busy;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= ProdWidth'(i_a);
                r_mplier <= i_b;
            end else if (r_busy) begin
                // Last bit carries negative weight (two's complement).
                if (r_mplier[0]) begin
                    if (r_cnt == MulCntW'(MulBWidth - 1)) r_acc <= r_acc - r_mcand;
                    else r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == MulCntW'(MulBWidth - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod      = r_acc;
    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
endmodule
`default_nettype wire

@@ rtl/odometry_frame_reprojection_core.sv @@
// Top level: odometry frame reprojection with quaternion dead reckoning.
// Usage:
//   i_req (sink) takes requests: opcode 0 stores the attitude quaternion and
//   yields nothing; opcode 1 is an odometry sample and yields one result on
//   o_res (source): the saturated accumulated position and latest attitude.
// Sequencing:
//   An attitude request is stored in the idle state. An odometry request runs
//   through one shared bit-serial multiplier, one product at a time: ten
//   quaternion products per matrix and nine entry products per rotation,
//   two matrices and two rotations, then the accumulation and the result.
//   One request is in work at a time.
//   Each entry product is exact floor(a*e/2^30) over a 36x34 serial multiply.
// Reset:
//   i_rst_n is synchronous, active low. Attitudes return to identity, the
//   accumulator to zero, and the next odometry sample counts as the first.
// Stall:
//   The result sits in the output register until o_res.ready; a waiting
//   result does not block acceptance of attitude requests, but an odometry
//   request waits until the previous result is taken.
`default_nettype none
module odometry_frame_reprojection_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ofr_in_if.sink    i_req,
    ofr_out_if.source o_res
);
    import ofr_pkg::*;

    t_state r_state, n_state;

    t_quat r_latest [4];
    t_quat r_latched [4];
    t_quat r_pquat [4];
    t_pos  r_ppos [3];
    t_pos  r_acc [3];
    logic  r_first;

    t_quat r_q [4];         // quaternion of the matrix under construction
    t_pos  r_cur [3];       // current sample position
    t_quat r_cquat [4];     // current sample quaternion
    t_quat r_att_snap [4];  // attitude to report
    logic signed [39:0] r_prods [10];
    t_ent  r_mat [9];
    t_vec  r_vin [3];       // input vector of the rotation
    logic signed [VecWidth+3:0] r_sum;
    t_vec  r_vout [3];
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic       r_mstart;

    logic signed [MulAWidth-1:0] w_ma;
    logic signed [MulBWidth-1:0] w_mb;
    logic signed [ProdWidth-1:0] w_prod;
    t_mul_ctl w_mctl;

    ofr_serial_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mstart),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod),
        .o_ctl  (w_mctl)
    );

    // Product order: ww xx yy zz xy xz yz wx wy wz.
    logic [1:0] w_pa, w_pb;
    always_comb begin
        case (r_idx)
            4'd0: begin w_pa = 2'd0; w_pb = 2'd0; end
            4'd1: begin w_pa = 2'd1; w_pb = 2'd1; end
            4'd2: begin w_pa = 2'd2; w_pb = 2'd2; end
            4'd3: begin w_pa = 2'd3; w_pb = 2'd3; end
            4'd4: begin w_pa = 2'd1; w_pb = 2'd2; end
            4'd5: begin w_pa = 2'd1; w_pb = 2'd3; end
            4'd6: begin w_pa = 2'd2; w_pb = 2'd3; end
            4'd7: begin w_pa = 2'd0; w_pb = 2'd1; end
            4'd8: begin w_pa = 2'd0; w_pb = 2'd2; end
            default: begin w_pa = 2'd0; w_pb = 2'd3; end
        endcase
    end

    // Rotation step idx = 3*i + j; entry R[i][j] (first) or R[j][i] (transpose).
    logic [1:0] w_ri, w_rj;
    logic [3:0] w_ent_idx;
    always_comb begin
        w_ri = 2'd0;
        w_rj = 2'd0;
        case (r_idx)
            4'd0: begin w_ri = 2'd0; w_rj = 2'd0; end
            4'd1: begin w_ri = 2'd0; w_rj = 2'd1; end
            4'd2: begin w_ri = 2'd0; w_rj = 2'd2; end
            4'd3: begin w_ri = 2'd1; w_rj = 2'd0; end
            4'd4: begin w_ri = 2'd1; w_rj = 2'd1; end
            4'd5: begin w_ri = 2'd1; w_rj = 2'd2; end
            4'd6: begin w_ri = 2'd2; w_rj = 2'd0; end
            4'd7: begin w_ri = 2'd2; w_rj = 2'd1; end
            default: begin w_ri = 2'd2; w_rj = 2'd2; end
        endcase
        if (r_state == ST_ROT2) w_ent_idx = 4'(w_rj) * 4'd3 + 4'(w_ri);
        else w_ent_idx = 4'(w_ri) * 4'd3 + 4'(w_rj);
    end

    always_comb begin
        if (r_state == ST_PROD || r_state == ST_PROD2) begin
            w_ma = MulAWidth'(r_q[w_pa]);
            w_mb = MulBWidth'(r_q[w_pb]);
        end else begin
            w_ma = MulAWidth'(r_vin[w_rj]);
            w_mb = MulBWidth'(r_mat[w_ent_idx]);
        end
    end

    // Matrix entries from the floored quaternion products.
    logic signed [39:0] w_raw [9];
    always_comb begin
        w_raw[0] = r_prods[0] + r_prods[1] - r_prods[2] - r_prods[3];
        w_raw[1] = 40'sd2 * (r_prods[4] + r_prods[9]);
        w_raw[2] = 40'sd2 * (r_prods[5] - r_prods[8]);
        w_raw[3] = 40'sd2 * (r_prods[4] - r_prods[9]);
        w_raw[4] = r_prods[0] - r_prods[1] + r_prods[2] - r_prods[3];
        w_raw[5] = 40'sd2 * (r_prods[6] + r_prods[7]);
        w_raw[6] = 40'sd2 * (r_prods[5] + r_prods[8]);
        w_raw[7] = 40'sd2 * (r_prods[6] - r_prods[7]);
        w_raw[8] = r_prods[0] - r_prods[1] - r_prods[2] + r_prods[3];
    end

    logic signed [ProdWidth-1:0] w_fl;
    logic signed [VecWidth+3:0]  w_sum_next;
    logic signed [VecWidth:0]    w_accsum [3];
    assign w_fl       = w_prod >>> FracBits;
    assign w_sum_next = r_sum + (VecWidth+4)'(w_fl);
    always_comb begin
        for (int k = 0; k < 3; k++)
            w_accsum[k] = (VecWidth+1)'(r_acc[k]) + (VecWidth+1)'(r_vout[k]);
    end

    logic w_in_fire, w_out_fire, w_last;
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || i_req.opcode == OpAttitude);
    assign w_in_fire   = i_req.valid && i_req.ready;
    assign w_out_fire  = o_res.valid && o_res.ready;

    always_comb begin
        n_state = r_state;
        w_last  = 1'b0;
        case (r_state)
            ST_IDLE: if (w_in_fire && i_req.opcode == OpOdometry) n_state = ST_PROD;
            ST_PROD: if (w_mctl.done && r_idx == 4'd9) n_state = ST_MAT1;
            ST_MAT1: n_state = ST_ROT1;
            ST_ROT1: if (w_mctl.done && r_idx == 4'd8) n_state = ST_PROD2;
            ST_PROD2: if (w_mctl.done && r_idx == 4'd9) n_state = ST_MAT2;
            ST_MAT2: n_state = ST_ROT2;
            ST_ROT2: if (w_mctl.done && r_idx == 4'd8) n_state = ST_OUT;
            ST_OUT: begin
                n_state = ST_IDLE;
                w_last  = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_latest[k]  <= (k == 0) ? t_quat'(64'sd1 <<< FracBits) : '0;
                r_latched[k] <= (k == 0) ? t_quat'(64'sd1 <<< FracBits) : '0;
            end
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_mstart    <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_mstart <= 1'b0;
            if (w_out_fire) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (i_req.opcode == OpAttitude) begin
                            r_latest[0] <= i_req.quat_w;
                            r_latest[1] <= i_req.quat_x;
                            r_latest[2] <= i_req.quat_y;
                            r_latest[3] <= i_req.quat_z;
                        end else begin
                            r_cur[0] <= i_req.pos_x;
                            r_cur[1] <= i_req.pos_y;
                            r_cur[2] <= i_req.pos_z;
                            r_cquat[0] <= i_req.quat_w;
                            r_cquat[1] <= i_req.quat_x;
                            r_cquat[2] <= i_req.quat_y;
                            r_cquat[3] <= i_req.quat_z;
                            // Difference zero on the first sample: previous = current.
                            for (int k = 0; k < 3; k++)
                                r_vin[k] <= r_first ? '0 : t_vec'(
                                    (DiffWidth)'(t_pos'(k == 0 ? i_req.pos_x :
                                     k == 1 ? i_req.pos_y : i_req.pos_z))
                                    - (DiffWidth)'(r_ppos[k]));
                            r_q[0] <= r_first ? t_quat'(i_req.quat_w) : r_pquat[0];
                            r_q[1] <= r_first ? t_quat'(i_req.quat_x) : r_pquat[1];
                            r_q[2] <= r_first ? t_quat'(i_req.quat_y) : r_pquat[2];
                            r_q[3] <= r_first ? t_quat'(i_req.quat_z) : r_pquat[3];
                            r_idx    <= '0;
                            r_mstart <= 1'b1;
                        end
                    end
                end
                ST_PROD, ST_PROD2: begin
                    if (w_mctl.done) begin
                        r_prods[r_idx] <= 40'(w_fl);
                        if (r_idx != 4'd9) begin
                            r_idx    <= r_idx + 1'b1;
                            r_mstart <= 1'b1;
                        end
                    end
                end
                ST_MAT1, ST_MAT2: begin
                    for (int k = 0; k < 9; k++) r_mat[k] <= sat_ent(w_raw[k]);
                    r_idx    <= '0;
                    r_sum    <= '0;
                    r_mstart <= 1'b1;
                end
                ST_ROT1, ST_ROT2: begin
                    if (w_mctl.done) begin
                        if (w_rj == 2'd2) begin
                            r_vout[w_ri] <= sat_vec(w_sum_next);
                            r_sum        <= '0;
                        end else begin
                            r_sum <= w_sum_next;
                        end
                        if (r_idx != 4'd8) begin
                            r_idx    <= r_idx + 1'b1;
                            r_mstart <= 1'b1;
                        end else if (r_state == ST_ROT1) begin
                            // Hand the body-frame vector on; rebuild with latched attitude.
                            r_vin[0] <= r_vout[0];
                            r_vin[1] <= r_vout[1];
                            r_vin[2] <= sat_vec(w_sum_next);
                            for (int k = 0; k < 4; k++) r_q[k] <= r_latched[k];
                            r_idx    <= '0;
                            r_mstart <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k]  <= sat_pos(w_accsum[k]);
                        r_ppos[k] <= r_cur[k];
                    end
                    for (int k = 0; k < 4; k++) begin
                        r_pquat[k]    <= r_cquat[k];
                        r_latched[k]  <= r_latest[k];
                        r_att_snap[k] <= r_latest[k];
                    end
                    r_first     <= 1'b0;
                    r_out_valid <= w_last;
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.acc_x = r_acc[0];
    assign o_res.acc_y = r_acc[1];
    assign o_res.acc_z = r_acc[2];
    assign o_res.att_w = r_att_snap[0];
    assign o_res.att_x = r_att_snap[1];
    assign o_res.att_y = r_att_snap[2];
    assign o_res.att_z = r_att_snap[3];

`ifndef SYNTHESIS
    a_no_odom_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !(w_in_fire && i_req.opcode == OpOdometry))
        else $error("odometry request accepted over pending result");
    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mstart |-> !w_mctl.busy)
        else $error("multiplier restarted while busy");
    a_result_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_out_valid)
        else $error("result not raised after accumulation");
`endif
endmodule
`default_nettype wire
